// ----- hw/rtl/apr_pkg.sv -----
package apr_pkg;

    // Fixed field widths of the external interface.
    localparam int unsigned COUNT_W     = 32;
    localparam int unsigned FRAME_IDX_W = 4;
    localparam int unsigned CFG_W       = 5;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    // Register map, by word index.
    localparam logic [0:0] REG_ACTIVE_FRAMES = 1'b0;

    // Value of active_frames after reset.
    localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

    // Result of one reference, apart from the evicted page number.
    typedef struct packed {
        logic                   hit;
        logic [FRAME_IDX_W-1:0] frame_index;
        logic                   evicted_valid;
        logic [COUNT_W-1:0]     hit_total;
        logic [COUNT_W-1:0]     miss_total;
    } t_result;

endpackage

// ----- hw/rtl/apr_ram.sv -----
module apr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/apr_ctrl.sv -----
module apr_ctrl #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned AGE_BITS   = 32,
    parameter int unsigned PAGE_BITS  = 20,
    localparam int unsigned IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
    localparam int unsigned CNT_W     = $clog2(MAX_FRAMES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [CNT_W-1:0]     i_frames,
    input  logic                 i_res_ready,
    output logic                 o_busy,
    output logic                 o_done,
    output apr_pkg::t_result     o_res,
    output logic [PAGE_BITS-1:0] o_ev_page
);

    localparam int unsigned WORD_W = PAGE_BITS + AGE_BITS;
    localparam logic [AGE_BITS-1:0] AGE_TOP = {1'b1, {(AGE_BITS-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIX  = 4'b0100,
        S_POST = 4'b1000
    } t_state;

    t_state                        r_state;
    logic [PAGE_BITS-1:0]          r_page;
    logic [CNT_W-1:0]              r_n;
    logic [CNT_W-1:0]              r_rd_idx;
    logic                          r_dvalid;
    logic [IDX_W-1:0]              r_d_idx;
    logic                          r_hit;
    logic [IDX_W-1:0]              r_hit_idx;
    logic [AGE_BITS-1:0]           r_hit_age;
    logic                          r_free;
    logic [IDX_W-1:0]              r_free_idx;
    logic                          r_have_min;
    logic [AGE_BITS-1:0]           r_min;
    logic [IDX_W-1:0]              r_min_idx;
    logic [PAGE_BITS-1:0]          r_min_tag;
    logic [MAX_FRAMES-1:0]         r_valid;
    logic [apr_pkg::COUNT_W-1:0]   r_hit_cnt;
    logic [apr_pkg::COUNT_W-1:0]   r_miss_cnt;
    apr_pkg::t_result              r_res;
    logic [PAGE_BITS-1:0]          r_ev_page;

    logic [apr_pkg::COUNT_W-1:0]   n_hit_cnt;
    logic [apr_pkg::COUNT_W-1:0]   n_miss_cnt;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 proc;
    logic                 last;
    logic                 ent_valid;
    logic [PAGE_BITS-1:0] ent_tag;
    logic [AGE_BITS-1:0]  ent_age;
    logic [IDX_W-1:0]     slot;
    logic [IDX_W+3:0]     slot_ext;
    logic [AGE_BITS-1:0]  fix_age;
    logic                 evict;

    apr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_FRAMES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A frame that was never filled reads as age zero; its tag is not used.
    assign ent_valid = r_valid[r_d_idx];
    assign ent_tag   = ram_rdata[AGE_BITS +: PAGE_BITS];
    assign ent_age   = ent_valid ? ram_rdata[AGE_BITS-1:0] : '0;

    assign ram_re    = (r_state == S_SCAN) && (r_rd_idx < r_n);
    assign ram_raddr = r_rd_idx[IDX_W-1:0];

    assign proc = (r_state == S_SCAN) && r_dvalid;
    assign last = proc && ((CNT_W'(r_d_idx) + CNT_W'(1)) == r_n);

    assign slot     = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_min_idx);
    assign slot_ext = {4'b0000, slot};
    assign evict    = !r_hit && !r_free;
    assign fix_age  = r_hit ? ((r_hit_age >> 1) | AGE_TOP) : AGE_TOP;

    // Each scanned entry is written back aged by one step; the chosen frame
    // gets its final word in the fix-up cycle.
    assign ram_we    = proc || (r_state == S_FIX);
    assign ram_waddr = (r_state == S_FIX) ? slot : r_d_idx;
    assign ram_wdata = (r_state == S_FIX) ? {r_page, fix_age} : {ent_tag, ent_age >> 1};

    assign n_hit_cnt  = (r_hit && (r_hit_cnt != '1))
                      ? r_hit_cnt + apr_pkg::COUNT_W'(1) : r_hit_cnt;
    assign n_miss_cnt = (!r_hit && (r_miss_cnt != '1))
                      ? r_miss_cnt + apr_pkg::COUNT_W'(1) : r_miss_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_hit_cnt  <= '0;
            r_miss_cnt <= '0;
            r_dvalid   <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_page     <= i_page;
                        r_n        <= i_frames;
                        r_rd_idx   <= '0;
                        r_dvalid   <= 1'b0;
                        r_hit      <= 1'b0;
                        r_free     <= 1'b0;
                        r_have_min <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // The read port is already past the range when the last entry
                    // is processed, so the data-valid flag drops by itself.
                    r_dvalid <= ram_re;
                    r_d_idx  <= ram_raddr;
                    if (ram_re) begin
                        r_rd_idx <= r_rd_idx + CNT_W'(1);
                    end
                    if (proc) begin
                        if (!r_hit && ent_valid && (ent_tag == r_page)) begin
                            r_hit     <= 1'b1;
                            r_hit_idx <= r_d_idx;
                            r_hit_age <= ent_age;
                        end
                        if (!r_free && !ent_valid) begin
                            r_free     <= 1'b1;
                            r_free_idx <= r_d_idx;
                        end
                        if (!r_have_min || (ent_age < r_min)) begin
                            r_have_min <= 1'b1;
                            r_min      <= ent_age;
                            r_min_idx  <= r_d_idx;
                            r_min_tag  <= ent_tag;
                        end
                    end
                    if (last) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_valid[slot]       <= 1'b1;
                    r_hit_cnt           <= n_hit_cnt;
                    r_miss_cnt          <= n_miss_cnt;
                    r_res.hit           <= r_hit;
                    r_res.frame_index   <= slot_ext[3:0];
                    r_res.evicted_valid <= evict;
                    r_res.hit_total     <= n_hit_cnt;
                    r_res.miss_total    <= n_miss_cnt;
                    r_ev_page           <= evict ? r_min_tag : '0;
                    r_state             <= S_POST;
                end
                S_POST: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy    = (r_state != S_IDLE);
    assign o_done    = (r_state == S_POST) && i_res_ready;
    assign o_res     = r_res;
    assign o_ev_page = r_ev_page;

    // The write-back trails the read by one entry, so they never collide.
    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("RAM read and write hit the same frame in one cycle");

    a_hit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIX) && r_hit) |-> r_valid[r_hit_idx])
        else $error("hit recorded on a frame that is not valid");

    a_evict_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_FIX) && evict) |-> r_have_min)
        else $error("eviction without a minimum-age candidate");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |-> (CNT_W'(r_d_idx) < r_n))
        else $error("scan processed a frame beyond the active range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after a result");

endmodule

// ----- hw/rtl/aging_page_replacement.sv -----
// Channel   Direction  Handshake                       Payload
// in        input      i_in_valid / o_in_stall         i_page_id
// out       output     o_out_valid / i_out_stall       o_hit, o_frame_index, o_evicted_valid,
//                                                      o_evicted_page, o_hit_total, o_miss_total
// cfg       APB        psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// The frame table sits in one RAM that is swept one frame per cycle through its single read
// port; that sweep sets the rate.
// Reset is synchronous and active low. It clears all valid bits and the totals, and frames that
// are not valid read as age zero, so no clearing pass is needed; it sets active_frames to 16.
// A stalled output word is held in the output register while the next word is accepted and
// scanned; the sequencer waits for the output register before it hands over a new result.
module aging_page_replacement #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned AGE_BITS   = 32,
    parameter int unsigned PAGE_BITS  = 20
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [PAGE_BITS-1:0]                i_page_id,

    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic [apr_pkg::FRAME_IDX_W-1:0]     o_frame_index,
    output logic                                o_evicted_valid,
    output logic [PAGE_BITS-1:0]                o_evicted_page,
    output logic [apr_pkg::COUNT_W-1:0]         o_hit_total,
    output logic [apr_pkg::COUNT_W-1:0]         o_miss_total,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [apr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [apr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [apr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);

    logic [apr_pkg::CFG_W-1:0] r_active;
    logic [CNT_W-1:0]          frames;
    logic                      cfg_sel;
    logic                      cfg_we;

    logic                      start;
    logic                      busy;
    logic                      done;
    logic                      res_ready;
    apr_pkg::t_result          res;
    logic [PAGE_BITS-1:0]      ev_page;

    logic                      r_out_valid;
    apr_pkg::t_result          r_out;
    logic [PAGE_BITS-1:0]      r_out_ev_page;

    // Configuration port. Registers are word addressed; the low address bits select a byte
    // lane and are ignored. Writes always complete in the access cycle.
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == apr_pkg::REG_ACTIVE_FRAMES);
    assign cfg_we  = psel && penable && pwrite && cfg_sel;
    assign prdata  = cfg_sel ? {{(apr_pkg::APB_DATA_W - apr_pkg::CFG_W){1'b0}}, r_active}
                             : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= apr_pkg::ACTIVE_RESET;
        end else if (cfg_we) begin
            r_active <= pwdata[apr_pkg::CFG_W-1:0];
        end
    end

    // A frame count of zero acts as one; any count above the table size acts as the table size.
    always_comb begin
        if (r_active == '0) begin
            frames = CNT_W'(1);
        end else if (32'(r_active) > MAX_FRAMES) begin
            frames = CNT_W'(MAX_FRAMES);
        end else begin
            frames = CNT_W'(r_active);
        end
    end

    // The sequencer accepts a reference only while idle.
    assign o_in_stall = busy;
    assign start      = i_in_valid && !busy;

    // The result register can take a new word when empty or when its word leaves now.
    assign res_ready = !r_out_valid || !i_out_stall;

    apr_ctrl #(
        .MAX_FRAMES (MAX_FRAMES),
        .AGE_BITS   (AGE_BITS),
        .PAGE_BITS  (PAGE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_page      (i_page_id),
        .i_frames    (frames),
        .i_res_ready (res_ready),
        .o_busy      (busy),
        .o_done      (done),
        .o_res       (res),
        .o_ev_page   (ev_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_out         <= res;
            r_out_ev_page <= ev_page;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_hit           = r_out.hit;
    assign o_frame_index   = r_out.frame_index;
    assign o_evicted_valid = r_out.evicted_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_hit_total     = r_out.hit_total;
    assign o_miss_total    = r_out.miss_total;

endmodule

// ----- verif/aging_page_replacement_checker.sv -----
module aging_page_replacement_checker #(
    parameter int unsigned MAX_FRAMES = 16,
    parameter int unsigned AGE_BITS   = 32,
    parameter int unsigned PAGE_BITS  = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [PAGE_BITS-1:0]             i_page_id,

    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic                             i_hit,
    input  logic [apr_pkg::FRAME_IDX_W-1:0]  i_frame_index,
    input  logic                             i_evicted_valid,
    input  logic [PAGE_BITS-1:0]             i_evicted_page,
    input  logic [apr_pkg::COUNT_W-1:0]      i_hit_total,
    input  logic [apr_pkg::COUNT_W-1:0]      i_miss_total,

    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [apr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [apr_pkg::APB_DATA_W-1:0]   pwdata,
    input  logic                             pready,

    output int                               o_error_count,
    output int                               o_pending,
    output int                               o_checked,
    output int                               o_evictions
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [apr_pkg::APB_ADDR_W-1:0] ADDR_ACTIVE_FRAMES =
        apr_pkg::APB_ADDR_W'(4 * apr_pkg::REG_ACTIVE_FRAMES);

    typedef struct packed {
        apr_pkg::t_result     res;
        logic [PAGE_BITS-1:0] evicted_page;
    } t_outcome;

    // Shadow copy of the frame table and the totals.
    logic [PAGE_BITS-1:0]          shadow_tag   [MAX_FRAMES];
    logic                          shadow_valid [MAX_FRAMES];
    logic [AGE_BITS-1:0]           shadow_age   [MAX_FRAMES];
    logic [apr_pkg::COUNT_W-1:0]   shadow_hits;
    logic [apr_pkg::COUNT_W-1:0]   shadow_misses;
    logic [apr_pkg::CFG_W-1:0]     shadow_frames;

    t_outcome outcome_q [$];

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
                 $time, o_checked, what, got, want);
        o_error_count++;
    endtask

    // Looks up one page reference, updates the shadow table and returns the word it must cause.
    task automatic resolve_reference(input logic [PAGE_BITS-1:0] page, output t_outcome outcome);
        int unsigned span;
        int unsigned idx;
        int unsigned slot;
        logic found;
        logic have_free;
        logic have_min;
        logic [AGE_BITS-1:0] best;
        span = (shadow_frames == '0) ? 1 :
               (32'(shadow_frames) > MAX_FRAMES) ? MAX_FRAMES : 32'(shadow_frames);
        found     = 1'b0;
        have_free = 1'b0;
        have_min  = 1'b0;
        best      = '0;
        slot      = 0;
        outcome   = '0;
        for (idx = 0; idx < span; idx++) begin
            if (!found && shadow_valid[idx] && shadow_tag[idx] == page) begin
                slot  = idx;
                found = 1'b1;
            end
        end
        if (found) begin
            if (shadow_hits != '1) shadow_hits++;
        end else begin
            if (shadow_misses != '1) shadow_misses++;
            // The first free frame wins; otherwise the oldest valid frame, lowest index on ties.
            for (idx = 0; idx < span; idx++) begin
                if (!have_free) begin
                    if (!shadow_valid[idx]) begin
                        slot      = idx;
                        have_free = 1'b1;
                    end else if (!have_min || shadow_age[idx] < best) begin
                        best     = shadow_age[idx];
                        slot     = idx;
                        have_min = 1'b1;
                    end
                end
            end
            if (!have_free) begin
                outcome.res.evicted_valid = 1'b1;
                outcome.evicted_page      = shadow_tag[slot];
                o_evictions++;
            end
            shadow_age[slot]   = '0;
            shadow_tag[slot]   = page;
            shadow_valid[slot] = 1'b1;
        end
        for (idx = 0; idx < span; idx++)
            shadow_age[idx] = shadow_age[idx] >> 1;
        shadow_age[slot][AGE_BITS-1] = 1'b1;
        outcome.res.hit         = found;
        outcome.res.frame_index = apr_pkg::FRAME_IDX_W'(slot);
        outcome.res.hit_total   = shadow_hits;
        outcome.res.miss_total  = shadow_misses;
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_FRAMES; k++) begin
                shadow_tag[k]   = '0;
                shadow_valid[k] = 1'b0;
                shadow_age[k]   = '0;
            end
            shadow_hits   = '0;
            shadow_misses = '0;
            shadow_frames = apr_pkg::ACTIVE_RESET;
            outcome_q.delete();
            o_error_count = 0;
            o_checked     = 0;
            o_evictions   = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_ACTIVE_FRAMES)
                shadow_frames = pwdata[apr_pkg::CFG_W-1:0];
            // Results are taken before new references so a word is never matched with the
            // reference accepted at the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    report_mismatch("word with no reference pending, hit_total", i_hit_total, 0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_hit !== want.res.hit)
                        report_mismatch("hit", i_hit, want.res.hit);
                    if (i_frame_index !== want.res.frame_index)
                        report_mismatch("frame_index", i_frame_index, want.res.frame_index);
                    if (i_evicted_valid !== want.res.evicted_valid)
                        report_mismatch("evicted_valid", i_evicted_valid,
                                        want.res.evicted_valid);
                    if (i_evicted_page !== want.evicted_page)
                        report_mismatch("evicted_page", i_evicted_page, want.evicted_page);
                    if (i_hit_total !== want.res.hit_total)
                        report_mismatch("hit_total", i_hit_total, want.res.hit_total);
                    if (i_miss_total !== want.res.miss_total)
                        report_mismatch("miss_total", i_miss_total, want.res.miss_total);
                    o_checked++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                resolve_reference(i_page_id, want);
                outcome_q.push_back(want);
            end
        end
        o_pending = outcome_q.size();
    end

endmodule

// ----- verif/aging_page_replacement_tb.sv -----
module aging_page_replacement_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAMES   = 16;
    localparam int unsigned AGE_W    = 32;
    localparam int unsigned PAGE_W   = 20;
    localparam int unsigned PAGE_MAX = (1 << PAGE_W) - 1;

    localparam logic [apr_pkg::APB_ADDR_W-1:0] ADDR_ACTIVE_FRAMES =
        apr_pkg::APB_ADDR_W'(4 * apr_pkg::REG_ACTIVE_FRAMES);

    // After the last word we wait longer than one full-table reference takes, with some margin,
    // before touching the register.
    localparam int SETTLE_CYCLES = FRAMES + 12;

    // Cycles without any accepted word or register access before the run is declared hung.
    // The slowest legal stretch is a long sender gap or a long receiver stall plus one full-table
    // reference, so this is many times that.
    localparam int HANG_LIMIT = 4000;

    localparam int PHASE_COUNT = 11;
    localparam int PHASE_WORDS = 85;
    localparam int POOL_SIZE   = FRAMES + 4;

    // Frame-count settings for the random phases. They include the extremes, the zero value
    // that acts as one frame, and values above the table size that act as all frames.
    logic [apr_pkg::CFG_W-1:0] frame_settings [PHASE_COUNT] = '{
        5'd1, 5'd0, 5'd5, 5'd31, 5'd3, 5'd17, 5'd16, 5'd8, 5'd2, 5'd12, 5'd16
    };

    logic                                i_clk   = 1'b0;
    logic                                i_rst_n = 1'b0;

    logic                                i_in_valid  = 1'b0;
    logic                                o_in_stall;
    logic [PAGE_W-1:0]                   i_page_id   = '0;

    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic                                o_hit;
    logic [apr_pkg::FRAME_IDX_W-1:0]     o_frame_index;
    logic                                o_evicted_valid;
    logic [PAGE_W-1:0]                   o_evicted_page;
    logic [apr_pkg::COUNT_W-1:0]         o_hit_total;
    logic [apr_pkg::COUNT_W-1:0]         o_miss_total;

    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [apr_pkg::APB_ADDR_W-1:0]      paddr   = '0;
    logic [apr_pkg::APB_DATA_W-1:0]      pwdata  = '0;
    logic [apr_pkg::APB_DATA_W-1:0]      prdata;
    logic                                pready;

    int error_count;
    int pending_words;
    int checked_words;
    int eviction_count;

    // Idle behavior of the two sides: 0 keeps the side busy every cycle, 1 idles now and
    // then, 2 idles often. Both are changed from phase to phase.
    int gap_mode   = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int idle_run   = 0;
    int words_sent = 0;

    logic [PAGE_W-1:0] page_pool [POOL_SIZE];

    always #5 i_clk = ~i_clk;

    aging_page_replacement #(
        .MAX_FRAMES (FRAMES),
        .AGE_BITS   (AGE_W),
        .PAGE_BITS  (PAGE_W)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page_id       (i_page_id),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_hit           (o_hit),
        .o_frame_index   (o_frame_index),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_hit_total     (o_hit_total),
        .o_miss_total    (o_miss_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    // The checker sits beside the block, predicts every result word and compares it.
    aging_page_replacement_checker #(
        .MAX_FRAMES (FRAMES),
        .AGE_BITS   (AGE_W),
        .PAGE_BITS  (PAGE_W)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_page_id       (i_page_id),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_hit           (o_hit),
        .i_frame_index   (o_frame_index),
        .i_evicted_valid (o_evicted_valid),
        .i_evicted_page  (o_evicted_page),
        .i_hit_total     (o_hit_total),
        .i_miss_total    (o_miss_total),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_error_count   (error_count),
        .o_pending       (pending_words),
        .o_checked       (checked_words),
        .o_evictions     (eviction_count)
    );

    // Receiver back-pressure. A stall burst is mostly short, now and then long. With the
    // mode at zero the receiver takes every word at once.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (stall_mode != 0 &&
                     $urandom_range(0, 99) < (stall_mode == 1 ? 15 : 40)) begin
            stall_left  <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                       : $urandom_range(0, 3);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Hang detection: counts cycles in which neither channel moves a word and the register
    // port is quiet.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel) begin
            idle_run <= 0;
        end else if (idle_run >= HANG_LIMIT) begin
            $display("Timeout: no progress for %0d cycles, %0d results still pending",
                     HANG_LIMIT, pending_words);
            $display("DONE: errors detected");
            $finish;
        end else begin
            idle_run <= idle_run + 1;
        end
    end

    // Number of idle cycles before the next reference: mostly none or a few, rarely many.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (gap_mode == 0)
            return 0;
        if (roll < (gap_mode == 1 ? 75 : 40))
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Frames that actually take part for a given register value.
    function automatic int unsigned frames_in_play(input logic [apr_pkg::CFG_W-1:0] setting);
        if (setting == '0)
            return 1;
        if (32'(setting) > FRAMES)
            return FRAMES;
        return 32'(setting);
    endfunction

    // Presents one page reference and holds it until the block takes it. Valid is only
    // lowered when a gap precedes the word, so it never toggles twice in one step.
    task automatic send_word(input logic [PAGE_W-1:0] page);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_page_id  <= page;
        do @(posedge i_clk); while (o_in_stall);
        words_sent++;
    endtask

    // Waits until every expected word has come back, then lets the block settle.
    task automatic wait_idle();
        do @(posedge i_clk); while (pending_words != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Setup cycle, then access cycle held until pready. The upper data bits are random to
    // show that only the low five bits count.
    task automatic write_active_frames(input logic [apr_pkg::CFG_W-1:0] setting);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ACTIVE_FRAMES;
        pwdata  <= {(apr_pkg::APB_DATA_W-apr_pkg::CFG_W)'($urandom), setting};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random phase under a new frame count. Most references come from a working set a
    // little larger than the active frames, so hits, fills and evictions all happen often;
    // the rest are the extreme page numbers or arbitrary pages.
    task automatic run_phase(input logic [apr_pkg::CFG_W-1:0] setting);
        int unsigned live;
        int unsigned roll;
        logic [PAGE_W-1:0] page;
        wait_idle();
        write_active_frames(setting);
        live = frames_in_play(setting) + $urandom_range(1, 4);
        if (live > POOL_SIZE)
            live = POOL_SIZE;
        // Keep part of the old working set so that frames left outside a smaller range
        // can be hit again once the range grows.
        for (int k = 0; k < POOL_SIZE; k++) begin
            if ($urandom_range(0, 2) == 0)
                page_pool[k] = PAGE_W'($urandom_range(0, PAGE_MAX));
        end
        gap_mode   = $urandom_range(0, 2);
        stall_mode = $urandom_range(0, 2);
        for (int k = 0; k < PHASE_WORDS; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                page = page_pool[$urandom_range(0, live - 1)];
            else if (roll < 90)
                page = ($urandom_range(0, 1) == 1) ? PAGE_W'(PAGE_MAX) : '0;
            else
                page = PAGE_W'($urandom_range(0, PAGE_MAX));
            send_word(page);
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part under the reset frame count of 16. Page zero and the all-ones page
        // first, then hits on both, then fresh pages until the table is full, and then
        // misses that must evict the oldest frame.
        stall_mode = 1;
        send_word('0);
        send_word(PAGE_W'(PAGE_MAX));
        send_word('0);
        send_word(PAGE_W'(PAGE_MAX));
        for (int k = 1; k <= FRAMES - 2; k++)
            send_word(PAGE_W'(k));
        send_word(20'hABCDE);
        send_word(20'h55555);
        send_word('0);
        send_word(20'hAAAAA);
        i_in_valid <= 1'b0;

        for (int k = 0; k < POOL_SIZE; k++)
            page_pool[k] = PAGE_W'(k);
        page_pool[FRAMES - 1] = PAGE_W'(PAGE_MAX);

        for (int p = 0; p < PHASE_COUNT; p++)
            run_phase(frame_settings[p]);

        // Drain: the receiver stops stalling once all references are in.
        stall_mode = 0;
        wait_idle();

        $display("Summary: %0d page references over %0d frame-count settings, including zero",
                 words_sent, PHASE_COUNT + 1);
        $display("and values above the table size; %0d results checked, %0d with an eviction.",
                 checked_words, eviction_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/apr_pkg.sv
hw/rtl/apr_ram.sv
hw/rtl/apr_ctrl.sv
hw/rtl/aging_page_replacement.sv
verif/aging_page_replacement_checker.sv
verif/aging_page_replacement_tb.sv
